### hdl/scpc_pkg.sv
// scpc_pkg: shared types, constants and elaboration-time table functions
// for the soft polygon containment block; no dependencies
`timescale 1ns / 1ps
package scpc_pkg;

   localparam logic [63:0] Q31_ONE     = 64'h0000_0000_8000_0000;
   localparam logic [15:0] SLOPE_RESET = 16'd6554;
   localparam logic [15:0] UNIT_ONE    = 16'd16384;
   localparam logic [16:0] PROD_ONE    = 17'd65536;
   localparam int          SQRT_STEPS  = 26;
   localparam int          DIV_STEPS   = 16;

   typedef enum logic [1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_EVAL   = 2'd2
   } action_type;

   typedef enum logic {
      MODE_SQRT,
      MODE_DIV
   } iter_mode_type;

   typedef struct packed {
      logic          start;
      iter_mode_type mode;
   } iter_cmd_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_DIVX_GO,
      ST_DIVX_WAIT,
      ST_DIVY_GO,
      ST_DIVY_WAIT,
      ST_WRITE,
      ST_EV_READ,
      ST_EV_M1,
      ST_EV_M2,
      ST_EV_T,
      ST_EV_IDX,
      ST_EV_LOOK,
      ST_EV_FACT,
      ST_EV_PROD,
      ST_DONE
   } state_type;

   // floor division of a series term by its index
   function automatic logic [63:0] div_by_term(input logic [63:0] x, input int n);
      logic [63:0] r;
      unique case (n)
         1:  r = x;
         2:  r = x / 2;
         3:  r = x / 3;
         4:  r = x / 4;
         5:  r = x / 5;
         6:  r = x / 6;
         7:  r = x / 7;
         8:  r = x / 8;
         9:  r = x / 9;
         10: r = x / 10;
         11: r = x / 11;
         12: r = x / 12;
         13: r = x / 13;
         14: r = x / 14;
         15: r = x / 15;
         16: r = x / 16;
         17: r = x / 17;
         18: r = x / 18;
         19: r = x / 19;
         20: r = x / 20;
         21: r = x / 21;
         22: r = x / 22;
         23: r = x / 23;
         24: r = x / 24;
         default: r = x;
      endcase
      return r;
   endfunction

   // e^-f in q0.31 by a truncated alternating series
   function automatic logic [63:0] neg_exp_q31(input logic [63:0] f);
      logic [63:0] term;
      logic [63:0] fl;
      longint      sum;
      fl   = (f > Q31_ONE) ? Q31_ONE : f;
      sum  = longint'(Q31_ONE);
      term = Q31_ONE;
      for (int n = 1; n <= 24; n++) begin
         term = div_by_term((term * fl) >> 31, n);
         if ((n & 1) == 1)
            sum = sum - longint'(term);
         else
            sum = sum + longint'(term);
      end
      if (sum < 0)
         sum = 0;
      if (sum > longint'(Q31_ONE))
         sum = longint'(Q31_ONE);
      return 64'(sum);
   endfunction

   // e^-(ip + frac) in q0.31
   function automatic logic [63:0] sig_weight(input logic [63:0] rem_q, input logic [63:0] ip);
      logic [63:0] e1;
      logic [63:0] w;
      e1 = neg_exp_q31(Q31_ONE);
      w  = neg_exp_q31(rem_q);
      for (int j = 0; j < 16; j++) begin
         if (64'(j) < ip)
            w = (w * e1) >> 31;
      end
      return w;
   endfunction

endpackage

### hdl/scpc_ram.sv
// scpc_ram: generic single write port RAM with registered read
// no dependencies
`timescale 1ns / 1ps
module scpc_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en)
         mem_ff[wr_addr] <= wr_data;
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

### hdl/scpc_sig_rom.sv
// scpc_sig_rom: logistic sigmoid table built at elaboration, registered read
// depends on scpc_pkg
`timescale 1ns / 1ps
module scpc_sig_rom #(
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   output logic [16:0]              data
);
   logic [16:0] rom_w [DEPTH];
   logic [16:0] data_ff;

   for (genvar k = 0; k < DEPTH; k++) begin : g_entry
      localparam logic [63:0] NUM  = 64'(16 * k);
      localparam logic [63:0] IP   = NUM / DEPTH;
      localparam logic [63:0] REMQ = ((NUM % DEPTH) << 31) / DEPTH;
      localparam logic [63:0] W    = scpc_pkg::sig_weight(REMQ, IP);
      localparam logic [63:0] DEN  = scpc_pkg::Q31_ONE + W;
      localparam logic [63:0] VAL  = ((64'd1 << 47) + DEN / 2) / DEN;
      localparam logic [63:0] CLIP = (VAL > 64'd65536) ? 64'd65536 : VAL;
      assign rom_w[k] = CLIP[16:0];
   end

   always_ff @(posedge clock) begin
      data_ff <= rom_w[addr];
   end

   assign data = data_ff;
endmodule

### hdl/scpc_mul.sv
// scpc_mul: shared signed 35x18 multiplier with registered product
// no dependencies
`timescale 1ns / 1ps
module scpc_mul (
   input  logic        clock,
   input  logic [34:0] op_a,
   input  logic [17:0] op_b,
   output logic [52:0] product
);
   logic [52:0] product_ff;

   always_ff @(posedge clock) begin
      product_ff <= 53'($signed(op_a) * $signed(op_b));
   end

   assign product = product_ff;
endmodule

### hdl/scpc_iter.sv
// scpc_iter: iterative square root and restoring divider sharing one subtractor
// depends on scpc_pkg
`timescale 1ns / 1ps
module scpc_iter (
   input  logic                   clock,
   input  logic                   reset,
   input  scpc_pkg::iter_cmd_type cmd,
   input  logic [51:0]            radicand,
   input  logic [40:0]            numer,
   input  logic [26:0]            denom,
   output logic                   busy,
   output logic [25:0]            result
);
   logic                    busy_ff, busy_in;
   logic [4:0]              cnt_ff, cnt_in;
   scpc_pkg::iter_mode_type mode_ff, mode_in;
   logic [28:0]             rem_ff, rem_in;
   logic [25:0]             acc_ff, acc_in;
   logic [51:0]             src_ff, src_in;
   logic [26:0]             den_ff, den_in;
   logic [28:0]             rem_sh;
   logic [28:0]             trial;
   logic [29:0]             diff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      mode_ff <= mode_in;
      rem_ff  <= rem_in;
      acc_ff  <= acc_in;
      src_ff  <= src_in;
      den_ff  <= den_in;
   end

   always_comb begin
      unique case (mode_ff)
         scpc_pkg::MODE_SQRT: begin
            rem_sh = {rem_ff[26:0], src_ff[51:50]};
            trial  = {1'b0, acc_ff, 2'b01};
         end
         scpc_pkg::MODE_DIV: begin
            rem_sh = {rem_ff[27:0], src_ff[51]};
            trial  = {2'b00, den_ff};
         end
         default: begin
            rem_sh = rem_ff;
            trial  = '0;
         end
      endcase
      diff = {1'b0, rem_sh} - {1'b0, trial};

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      mode_in = mode_ff;
      rem_in  = rem_ff;
      acc_in  = acc_ff;
      src_in  = src_ff;
      den_in  = den_ff;

      if (cmd.start) begin
         busy_in = 1'b1;
         mode_in = cmd.mode;
         acc_in  = '0;
         den_in  = denom;
         if (cmd.mode == scpc_pkg::MODE_SQRT) begin
            rem_in = '0;
            src_in = radicand;
            cnt_in = 5'(scpc_pkg::SQRT_STEPS);
         end else begin
            // high numerator bits are already below the divisor
            rem_in = 29'(numer[40:16]);
            src_in = {numer[15:0], 36'd0};
            cnt_in = 5'(scpc_pkg::DIV_STEPS);
         end
      end else if (busy_ff) begin
         rem_in = diff[29] ? rem_sh : diff[28:0];
         acc_in = {acc_ff[24:0], ~diff[29]};
         src_in = (mode_ff == scpc_pkg::MODE_SQRT) ? {src_ff[49:0], 2'b00}
                                                   : {src_ff[50:0], 1'b0};
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1)
            busy_in = 1'b0;
      end
   end

   assign busy   = busy_ff;
   assign result = acc_ff;
endmodule

### hdl/soft_convex_polygon_containment.sv
// soft_convex_polygon_containment: top level, sequencer around a shared multiplier,
// an iterative root/divide unit, the edge RAM and the sigmoid table
// sequence: a clear or ignored action goes straight to the result; append runs a 26-step root
// and two 16-step divides; evaluate walks each stored edge in turn (multiplier used 5 times per edge)
// throughput: one transaction at a time; the next is taken once the result is registered
// reset: synchronous, clears the edge count and control state, slope returns to 0.1
`timescale 1ns / 1ps
module soft_convex_polygon_containment #(
   parameter int MAX_EDGES           = 16,
   parameter int SIGMOID_TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_first_x,
   input  logic [15:0] req_first_y,
   input  logic [15:0] req_second_x,
   input  logic [15:0] req_second_y,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_instability,
   output logic        rsp_status,
   output logic [4:0]  rsp_edges_held,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   localparam int CW = $clog2(MAX_EDGES + 1);
   localparam int AW = $clog2(MAX_EDGES);
   localparam int IW = $clog2(SIGMOID_TABLE_DEPTH);

   scpc_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  total_ff, total_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [15:0]    slope_ff;
   logic [15:0]    fx_ff, fx_in, fy_ff, fy_in, sx_ff, sx_in, sy_ff, sy_in;
   logic [33:0]    acc_ff, acc_in;
   logic [25:0]    len_ff, len_in;
   logic [15:0]    ux_ff, ux_in, uy_ff, uy_in;
   logic [16:0]    p_ff, p_in;
   logic           neg_ff, neg_in, sat_ff, sat_in;
   logic [15:0]    inst_ff, inst_in;
   logic           status_ff, status_in;
   logic [15:0]    rsp_inst_ff, rsp_inst_in;
   logic           rsp_status_ff, rsp_status_in;
   logic [4:0]     rsp_held_ff, rsp_held_in;

   logic [34:0]    mul_a;
   logic [17:0]    mul_b;
   logic [52:0]    prod;
   scpc_pkg::iter_cmd_type iter_cmd;
   logic [51:0]    radicand;
   logic [40:0]    numer;
   logic           iter_busy;
   logic [25:0]    iter_result;
   logic           ram_we;
   logic [63:0]    ram_wdata, row;
   logic [16:0]    rom_data;

   logic [16:0]    dx, dy, ex, ey, mag_comp;
   logic [33:0]    sq_sum, signed_dist, round_sum;
   logic [50:0]    t_mag;
   logic [16:0]    factor;
   logic [15:0]    q_clip, unit_val;

   scpc_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   scpc_iter u_iter (
      .clock    (clock),
      .reset    (reset),
      .cmd      (iter_cmd),
      .radicand (radicand),
      .numer    (numer),
      .denom    ({len_ff, 1'b0}),
      .busy     (iter_busy),
      .result   (iter_result)
   );

   scpc_ram #(.WIDTH(64), .DEPTH(MAX_EDGES)) u_edge_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (total_ff[AW-1:0]),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (row)
   );

   scpc_sig_rom #(.DEPTH(SIGMOID_TABLE_DEPTH)) u_sig_rom (
      .clock (clock),
      .addr  (prod[34 +: IW]),
      .data  (rom_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= scpc_pkg::ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         slope_ff     <= scpc_pkg::SLOPE_RESET;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en)
            slope_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      fx_ff         <= fx_in;
      fy_ff         <= fy_in;
      sx_ff         <= sx_in;
      sy_ff         <= sy_in;
      acc_ff        <= acc_in;
      len_ff        <= len_in;
      ux_ff         <= ux_in;
      uy_ff         <= uy_in;
      p_ff          <= p_in;
      neg_ff        <= neg_in;
      sat_ff        <= sat_in;
      inst_ff       <= inst_in;
      status_ff     <= status_in;
      rsp_inst_ff   <= rsp_inst_in;
      rsp_status_ff <= rsp_status_in;
      rsp_held_ff   <= rsp_held_in;
   end

   always_comb begin
      dx        = {sx_ff[15], sx_ff} - {fx_ff[15], fx_ff};
      dy        = {sy_ff[15], sy_ff} - {fy_ff[15], fy_ff};
      ex        = {fx_ff[15], fx_ff} - {row[63], row[63:48]};
      ey        = {fy_ff[15], fy_ff} - {row[47], row[47:32]};
      sq_sum    = acc_ff + prod[33:0];
      radicand  = {2'b00, sq_sum, 16'd0};
      mag_comp  = (state_ff == scpc_pkg::ST_DIVX_GO)
                ? (dx[16] ? (17'd0 - dx) : dx)
                : (dy[16] ? (17'd0 - dy) : dy);
      numer     = {1'b0, mag_comp, 23'd0} + {15'd0, len_ff};
      signed_dist = prod[33:0] - acc_ff;
      t_mag     = prod[50] ? (51'd0 - prod[50:0]) : prod[50:0];
      if (sat_ff)
         factor = neg_ff ? 17'd0 : scpc_pkg::PROD_ONE;
      else
         factor = neg_ff ? (scpc_pkg::PROD_ONE - rom_data) : rom_data;
      round_sum = prod[33:0] + 34'd32768;
      q_clip    = (iter_result[15:0] > scpc_pkg::UNIT_ONE) ? scpc_pkg::UNIT_ONE
                                                          : iter_result[15:0];
      unit_val  = (state_ff == scpc_pkg::ST_DIVX_WAIT)
                ? (dx[16] ? (16'd0 - q_clip) : q_clip)
                : (dy[16] ? (16'd0 - q_clip) : q_clip);
      ram_wdata = {fx_ff, fy_ff, ux_ff, uy_ff};
   end

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      idx_in        = idx_ff;
      fx_in         = fx_ff;
      fy_in         = fy_ff;
      sx_in         = sx_ff;
      sy_in         = sy_ff;
      acc_in        = acc_ff;
      len_in        = len_ff;
      ux_in         = ux_ff;
      uy_in         = uy_ff;
      p_in          = p_ff;
      neg_in        = neg_ff;
      sat_in        = sat_ff;
      inst_in       = inst_ff;
      status_in     = status_ff;
      rsp_inst_in   = rsp_inst_ff;
      rsp_status_in = rsp_status_ff;
      rsp_held_in   = rsp_held_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      mul_a         = '0;
      mul_b         = '0;
      iter_cmd      = '{start: 1'b0, mode: scpc_pkg::MODE_SQRT};
      ram_we        = 1'b0;

      unique case (state_ff)
         scpc_pkg::ST_IDLE: begin
            if (req_valid) begin
               fx_in     = req_first_x;
               fy_in     = req_first_y;
               sx_in     = req_second_x;
               sy_in     = req_second_y;
               inst_in   = '0;
               status_in = 1'b0;
               unique case (scpc_pkg::action_type'(req_action))
                  scpc_pkg::ACT_CLEAR: begin
                     total_in = '0;
                     state_in = scpc_pkg::ST_DONE;
                  end
                  scpc_pkg::ACT_APPEND: begin
                     if (total_ff < CW'(MAX_EDGES)) begin
                        state_in = scpc_pkg::ST_SQ_X;
                     end else begin
                        status_in = 1'b1;
                        state_in  = scpc_pkg::ST_DONE;
                     end
                  end
                  scpc_pkg::ACT_EVAL: begin
                     p_in     = scpc_pkg::PROD_ONE;
                     idx_in   = '0;
                     state_in = scpc_pkg::ST_EV_READ;
                  end
                  default: begin
                     state_in = scpc_pkg::ST_DONE;
                  end
               endcase
            end
         end
         scpc_pkg::ST_SQ_X: begin
            mul_a    = {{18{dx[16]}}, dx};
            mul_b    = {dx[16], dx};
            state_in = scpc_pkg::ST_SQ_Y;
         end
         scpc_pkg::ST_SQ_Y: begin
            acc_in   = prod[33:0];
            mul_a    = {{18{dy[16]}}, dy};
            mul_b    = {dy[16], dy};
            state_in = scpc_pkg::ST_SQRT_GO;
         end
         scpc_pkg::ST_SQRT_GO: begin
            iter_cmd = '{start: 1'b1, mode: scpc_pkg::MODE_SQRT};
            state_in = scpc_pkg::ST_SQRT_WAIT;
         end
         scpc_pkg::ST_SQRT_WAIT: begin
            if (!iter_busy) begin
               len_in = iter_result;
               // zero-length edge keeps a null direction
               if (iter_result == '0) begin
                  ux_in    = '0;
                  uy_in    = '0;
                  state_in = scpc_pkg::ST_WRITE;
               end else begin
                  state_in = scpc_pkg::ST_DIVX_GO;
               end
            end
         end
         scpc_pkg::ST_DIVX_GO: begin
            iter_cmd = '{start: 1'b1, mode: scpc_pkg::MODE_DIV};
            state_in = scpc_pkg::ST_DIVX_WAIT;
         end
         scpc_pkg::ST_DIVX_WAIT: begin
            if (!iter_busy) begin
               ux_in    = unit_val;
               state_in = scpc_pkg::ST_DIVY_GO;
            end
         end
         scpc_pkg::ST_DIVY_GO: begin
            iter_cmd = '{start: 1'b1, mode: scpc_pkg::MODE_DIV};
            state_in = scpc_pkg::ST_DIVY_WAIT;
         end
         scpc_pkg::ST_DIVY_WAIT: begin
            if (!iter_busy) begin
               uy_in    = unit_val;
               state_in = scpc_pkg::ST_WRITE;
            end
         end
         scpc_pkg::ST_WRITE: begin
            ram_we   = 1'b1;
            total_in = total_ff + CW'(1);
            state_in = scpc_pkg::ST_DONE;
         end
         scpc_pkg::ST_EV_READ: begin
            if (idx_ff == total_ff) begin
               inst_in  = (p_ff == '0) ? 16'hFFFF : 16'(scpc_pkg::PROD_ONE - p_ff);
               state_in = scpc_pkg::ST_DONE;
            end else begin
               state_in = scpc_pkg::ST_EV_M1;
            end
         end
         scpc_pkg::ST_EV_M1: begin
            mul_a    = {{18{ex[16]}}, ex};
            mul_b    = {{2{row[15]}}, row[15:0]};
            state_in = scpc_pkg::ST_EV_M2;
         end
         scpc_pkg::ST_EV_M2: begin
            acc_in   = prod[33:0];
            mul_a    = {{18{ey[16]}}, ey};
            mul_b    = {{2{row[31]}}, row[31:16]};
            state_in = scpc_pkg::ST_EV_T;
         end
         scpc_pkg::ST_EV_T: begin
            mul_a    = {signed_dist[33], signed_dist};
            mul_b    = {2'b00, slope_ff};
            state_in = scpc_pkg::ST_EV_IDX;
         end
         scpc_pkg::ST_EV_IDX: begin
            // index = |t| * depth / 2^34, past the table when |t| reaches 2^34
            neg_in   = prod[50];
            sat_in   = |t_mag[50:34];
            mul_a    = {1'b0, t_mag[33:0]};
            mul_b    = 18'(SIGMOID_TABLE_DEPTH);
            state_in = scpc_pkg::ST_EV_LOOK;
         end
         scpc_pkg::ST_EV_LOOK: begin
            state_in = scpc_pkg::ST_EV_FACT;
         end
         scpc_pkg::ST_EV_FACT: begin
            mul_a    = {18'd0, p_ff};
            mul_b    = {1'b0, factor};
            state_in = scpc_pkg::ST_EV_PROD;
         end
         scpc_pkg::ST_EV_PROD: begin
            p_in     = round_sum[32:16];
            idx_in   = idx_ff + CW'(1);
            state_in = scpc_pkg::ST_EV_READ;
         end
         scpc_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_inst_in   = inst_ff;
               rsp_status_in = status_ff;
               rsp_held_in   = 5'(total_ff);
               state_in      = scpc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = scpc_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_ready       = (state_ff == scpc_pkg::ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_instability = rsp_inst_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_edges_held  = rsp_held_ff;
endmodule

### tb/tb.sv
// tb: self-checking bench for soft_convex_polygon_containment, directed table then random phases
// depends on scpc_pkg and the block; predicts results from its own model of the edge table or typed rows
`timescale 1ns / 1ps
module tb;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int EDGE_CAP = 16;
   localparam int SIG_DEPTH = 1024;
   localparam longint unsigned ONE_Q31 = 64'h8000_0000;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int RANDOM_ITEMS = 1840;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_action = scpc_pkg::ACT_CLEAR;
   logic [15:0] req_first_x = 0, req_first_y = 0, req_second_x = 0, req_second_y = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [15:0] rsp_instability;
   logic        rsp_status;
   logic [4:0]  rsp_edges_held;
   logic        csr_wr_en = 0;
   logic [15:0] csr_wr_data = 0;

   soft_convex_polygon_containment DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_action(req_action),
      .req_first_x(req_first_x), .req_first_y(req_first_y),
      .req_second_x(req_second_x), .req_second_y(req_second_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_instability(rsp_instability), .rsp_status(rsp_status),
      .rsp_edges_held(rsp_edges_held),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   typedef struct {
      logic [15:0] instability;
      logic        status;
      logic [4:0]  edges_held;
   } outcome_type;

   // predictor state
   int unsigned sig_lut[SIG_DEPTH];
   int unsigned slope_q16;
   int unsigned edge_count;
   int          org_x[EDGE_CAP], org_y[EDGE_CAP], dir_x[EDGE_CAP], dir_y[EDGE_CAP];
   outcome_type pending_outcomes[$];

   // typed expectation for the row being offered
   bit          row_typed = 0;
   outcome_type row_outcome;

   int  idle_pct = 0, stall_pct = 0;
   bit  hold_off = 0;
   int  fail_count = 0;
   int  cycle_count = 0;

   function automatic longint unsigned exp_neg_q31(longint unsigned f);
      longint sum;
      longint unsigned term;
      sum = longint'(ONE_Q31);
      term = ONE_Q31;
      if (f > ONE_Q31) f = ONE_Q31;
      for (int n = 1; n <= 24; n++) begin
         term = ((term * f) >> 31) / longint'(n);
         if (n % 2 == 1) sum -= longint'(term);
         else sum += longint'(term);
      end
      if (sum < 0) sum = 0;
      if (sum > longint'(ONE_Q31)) sum = longint'(ONE_Q31);
      return longint'(sum);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitpos;
      root = 0;
      bitpos = 64'd1 << 62;
      while (bitpos > v) bitpos >>= 2;
      while (bitpos != 0) begin
         if (v >= root + bitpos) begin
            v -= root + bitpos;
            root = (root >> 1) + bitpos;
         end else
            root >>= 1;
         bitpos >>= 2;
      end
      return root;
   endfunction

   function automatic int unit_part(longint comp, longint unsigned len8);
      longint unsigned mag, q;
      if (len8 == 0) return 0;
      mag = comp < 0 ? -comp : comp;
      q = ((mag << 23) + len8) / (2 * len8);
      if (q > 16384) q = 16384;
      return comp < 0 ? -int'(q) : int'(q);
   endfunction

   task automatic fill_sigmoid_lut();
      longint unsigned e1, w, den, v, num;
      e1 = exp_neg_q31(ONE_Q31);
      for (int k = 0; k < SIG_DEPTH; k++) begin
         num = 16 * k;
         w = exp_neg_q31(((num % SIG_DEPTH) << 31) / SIG_DEPTH);
         for (longint unsigned j = 0; j < num / SIG_DEPTH; j++) w = (w * e1) >> 31;
         den = ONE_Q31 + w;
         v = ((64'd1 << 47) + den / 2) / den;
         if (v > 65536) v = 65536;
         sig_lut[k] = 32'(v);
      end
   endtask

   function automatic outcome_type containment_predict(logic [1:0] act, logic [15:0] fx,
         logic [15:0] fy, logic [15:0] sx, logic [15:0] sy);
      outcome_type o;
      longint dx, dy, d, t, px, py;
      longint unsigned len8, mag, idx, f, p;
      o.instability = 0;
      o.status = 0;
      px = longint'($signed(fx));
      py = longint'($signed(fy));
      case (act)
         scpc_pkg::ACT_CLEAR: edge_count = 0;
         scpc_pkg::ACT_APPEND: begin
            if (edge_count >= EDGE_CAP)
               o.status = 1;
            else begin
               dx = longint'($signed(sx)) - px;
               dy = longint'($signed(sy)) - py;
               len8 = int_sqrt((dx * dx + dy * dy) << 16);
               org_x[edge_count] = int'(px);
               org_y[edge_count] = int'(py);
               dir_x[edge_count] = unit_part(dx, len8);
               dir_y[edge_count] = unit_part(dy, len8);
               edge_count++;
            end
         end
         scpc_pkg::ACT_EVAL: begin
            p = 65536;
            for (int i = 0; i < edge_count; i++) begin
               d = -longint'(dir_y[i]) * (px - org_x[i]) + longint'(dir_x[i]) * (py - org_y[i]);
               t = d * longint'(slope_q16);
               mag = t < 0 ? -t : t;
               idx = (mag * SIG_DEPTH) >> 34;
               if (idx >= SIG_DEPTH) f = (t >= 0) ? 65536 : 0;
               else f = (t >= 0) ? sig_lut[idx] : 65536 - sig_lut[idx];
               p = (p * f + 32768) >> 16;
            end
            o.instability = (65536 - p > 65535) ? 16'hFFFF : 16'(65536 - p);
         end
         default: ;
      endcase
      o.edges_held = 5'(edge_count);
      return o;
   endfunction

   // prediction and checking at each edge
   always @(posedge clock) begin
      outcome_type want, pred;
      if (!reset) begin
         if (csr_wr_en) slope_q16 = csr_wr_data;
         if (req_valid && req_ready) begin
            pred = containment_predict(req_action, req_first_x, req_first_y,
                                       req_second_x, req_second_y);
            pending_outcomes.insert(pending_outcomes.size(), row_typed ? row_outcome : pred);
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_outcomes.size() == 0) begin
               $error("result transaction with nothing expected");
               fail_count++;
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_instability !== want.instability) begin
                  $error("instability expected %0d actual %0d", want.instability, rsp_instability);
                  fail_count++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d actual %0d", want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_edges_held !== want.edges_held) begin
                  $error("edges_held expected %0d actual %0d", want.edges_held, rsp_edges_held);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock)
      rsp_ready <= !hold_off && ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic offer(logic [1:0] act, logic [15:0] fx, logic [15:0] fy,
                        logic [15:0] sx, logic [15:0] sy);
      int gap;
      req_valid <= 1;
      req_action <= act;
      req_first_x <= fx;
      req_first_y <= fy;
      req_second_x <= sx;
      req_second_y <= sy;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 6);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_and_write(logic [15:0] slope);
      req_valid <= 0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en <= 1;
      csr_wr_data <= slope;
      @(posedge clock);
      csr_wr_en <= 0;
   endtask

   function automatic logic [15:0] pick_coord();
      case ($urandom_range(9))
         0: return 16'(32'($urandom));
         1: return $urandom_range(1) ? 16'h8000 : 16'h7FFF;
         default: return 16'($signed($urandom_range(4000)) - 2000);
      endcase
   endfunction

   task automatic random_item();
      int r;
      r = $urandom_range(99);
      if (r < 6 || (edge_count >= EDGE_CAP && r < 40))
         offer(scpc_pkg::ACT_CLEAR, 16'($urandom), 16'($urandom), 16'($urandom),
               16'($urandom));
      else if (r < 40)
         offer(scpc_pkg::ACT_APPEND, pick_coord(), pick_coord(), pick_coord(), pick_coord());
      else if (r < 96)
         offer(scpc_pkg::ACT_EVAL, pick_coord(), pick_coord(), 16'($urandom), 16'($urandom));
      else
         offer(ACT_UNUSED, 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   typedef struct {
      logic [1:0]  act;
      logic [15:0] fx, fy, sx, sy;
      int          reps;
      bit          typed;
      logic [15:0] inst;
      logic        status;
      logic [4:0]  held;
   } stim_row_type;

   stim_row_type directed_rows[] = '{
      '{scpc_pkg::ACT_EVAL,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, 16'd0, 1'b0, 5'd0},
      '{ACT_UNUSED,           16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 16'd0, 1'b0, 5'd0},
      '{scpc_pkg::ACT_APPEND, 16'h0064, 16'h0064, 16'h0064, 16'h0064, 1, 1, 16'd0, 1'b0, 5'd1},
      '{scpc_pkg::ACT_EVAL,   16'h1234, 16'hABCD, 16'h0000, 16'h0000, 1, 1, 16'd32768, 1'b0,
        5'd1},
      '{scpc_pkg::ACT_CLEAR,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1, 16'd0, 1'b0, 5'd0},
      '{scpc_pkg::ACT_APPEND, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1, 0, 0, 0, 0},
      '{scpc_pkg::ACT_APPEND, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1, 0, 0, 0, 0},
      '{scpc_pkg::ACT_APPEND, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 1, 0, 0, 0, 0},
      '{scpc_pkg::ACT_APPEND, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 1, 0, 0, 0, 0},
      '{scpc_pkg::ACT_EVAL,   16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 0, 0, 0, 0},
      '{scpc_pkg::ACT_EVAL,   16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 1, 0, 0, 0, 0},
      '{scpc_pkg::ACT_EVAL,   16'h8000, 16'h8000, 16'h0000, 16'h0000, 1, 0, 0, 0, 0},
      '{scpc_pkg::ACT_EVAL,   16'h0005, 16'hFFFB, 16'h0000, 16'h0000, 1, 0, 0, 0, 0},
      '{scpc_pkg::ACT_APPEND, 16'h0000, 16'h03E8, 16'hFC18, 16'h0000, 12, 0, 0, 0, 0},
      '{scpc_pkg::ACT_APPEND, 16'h0001, 16'h0001, 16'h0002, 16'h0002, 1, 1, 16'd0, 1'b1,
        5'd16},
      '{scpc_pkg::ACT_EVAL,   16'h0010, 16'hFFF0, 16'h0000, 16'h0000, 1, 0, 0, 0, 0},
      '{scpc_pkg::ACT_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1, 16'd0, 1'b0, 5'd0}
   };

   logic [15:0] phase_slopes[4] = '{16'd65535, 16'd1, 16'd0, 16'd6554};
   int          phase_idle[4]   = '{0, 81, 0, 37};
   int          phase_stall[4]  = '{0, 0, 81, 37};

   initial begin
      fill_sigmoid_lut();
      slope_q16 = scpc_pkg::SLOPE_RESET;
      edge_count = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         for (int k = 0; k < directed_rows[i].reps; k++) begin
            // updated after the edge so the checker sees the row that was accepted
            row_typed <= directed_rows[i].typed;
            row_outcome.instability <= directed_rows[i].inst;
            row_outcome.status <= directed_rows[i].status;
            row_outcome.edges_held <= directed_rows[i].held;
            offer(directed_rows[i].act, directed_rows[i].fx, directed_rows[i].fy,
                  directed_rows[i].sx, directed_rows[i].sy);
         end
      end
      row_typed <= 0;

      for (int ph = 0; ph < 5; ph++) begin
         if (ph < 4) begin
            drain_and_write(phase_slopes[ph]);
            idle_pct = phase_idle[ph];
            stall_pct = phase_stall[ph];
         end else begin
            drain_and_write(16'($urandom_range(1, 65535)));
            idle_pct = 20;
            stall_pct = 20;
         end
         if (ph == 0) begin
            // long receiver hold-off while transactions keep coming
            fork
               begin
                  hold_off <= 1;
                  repeat (400) @(posedge clock);
                  hold_off <= 0;
               end
            join_none
         end
         repeat (RANDOM_ITEMS / 5) random_item();
      end
      req_valid <= 0;

      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (fail_count == 0 && pending_outcomes.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule

### filelist.f
hdl/scpc_pkg.sv
hdl/scpc_ram.sv
hdl/scpc_sig_rom.sv
hdl/scpc_mul.sv
hdl/scpc_iter.sv
hdl/soft_convex_polygon_containment.sv
tb/tb.sv
